FILE: rtl/dpirw_pkg.sv
// ----------------------------------------------------------------------------
// dpirw_pkg
// Shared constants and types of the INFO chunk resolution rewriter.
// ----------------------------------------------------------------------------
package dpirw_pkg;

  localparam int MAX_NESTING = 4;
  localparam int POS_W = 33;
  localparam int LVL_W = $clog2(MAX_NESTING + 1);
  localparam int IDX_W = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  localparam logic [31:0] ID_FORM  = 32'h464f524d;
  localparam logic [31:0] ID_DJVU  = 32'h444a5655;
  localparam logic [31:0] ID_DJVM  = 32'h444a564d;
  localparam logic [31:0] ID_INFO  = 32'h494e464f;
  localparam logic [31:0] ID_MAGIC = 32'h41542654;

  // Parser phases.
  localparam logic [2:0] PH_ID     = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_FORMID = 3'd2;
  localparam logic [2:0] PH_INFO   = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  localparam logic [15:0] DPI_RESET = 16'd300;

  // Register map.
  localparam logic REG_DPI = 1'b0;

  typedef struct packed {
    logic             push;
    logic [POS_W-1:0] push_end;
    logic             close;
    logic [POS_W-1:0] close_at;
    logic             clear;
  } stk_ctl_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             has_top;
    logic [POS_W-1:0] top_end;
  } stk_stat_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       patched;
    logic       malformed;
  } res_t;

endpackage

FILE: rtl/dpirw_stack.sv
// ----------------------------------------------------------------------------
// dpirw_stack
// Ends of the open forms and the nesting level; on a close, pops the ended forms from the top down.
// ----------------------------------------------------------------------------
module dpirw_stack (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  dpirw_pkg::stk_ctl_t ctl,
  output dpirw_pkg::stk_stat_t stat
);
  import dpirw_pkg::*;

  logic [POS_W-1:0] ends [MAX_NESTING];
  logic [POS_W-1:0] ends_view [MAX_NESTING];
  logic [LVL_W-1:0] level;
  logic [LVL_W-1:0] level_next;
  logic [LVL_W-1:0] lvl_push;
  logic [LVL_W-1:0] lvl_closed;
  logic [LVL_W-1:0] lvl_m1;
  logic [MAX_NESTING-1:0] ended;

  // A push lands before the close scan, so the new form can close at once.
  always_comb begin
    lvl_push = ctl.push ? level + LVL_W'(1) : level;
    for (int i = 0; i < MAX_NESTING; i++) begin
      ends_view[i] = (ctl.push && (level == LVL_W'(i))) ? ctl.push_end : ends[i];
      ended[i] = (ctl.close_at >= ends_view[i]);
    end
    lvl_closed = lvl_push;
    for (int i = MAX_NESTING - 1; i >= 0; i--) begin
      if ((lvl_closed == LVL_W'(i + 1)) && ended[i]) begin
        lvl_closed = LVL_W'(i);
      end
    end
    if (ctl.clear) begin
      level_next = '0;
    end else if (ctl.close) begin
      level_next = lvl_closed;
    end else begin
      level_next = lvl_push;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (step) begin
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && ctl.push) begin
      ends[level[IDX_W-1:0]] <= ctl.push_end;
    end
  end

  assign lvl_m1       = level - LVL_W'(1);
  assign stat.level   = level;
  assign stat.has_top = (level != '0);
  assign stat.top_end = ends[lvl_m1[IDX_W-1:0]];

endmodule

FILE: rtl/dpirw_core.sv
// ----------------------------------------------------------------------------
// dpirw_core
// Chunk header parser and INFO patch logic, one byte per step.
// ----------------------------------------------------------------------------
module dpirw_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_in,
  input  logic              is_last,
  input  logic [15:0]       target_dpi,
  output dpirw_pkg::res_t   res
);
  import dpirw_pkg::*;

  logic [POS_W-1:0] pos, pos_next;
  logic [2:0]       phase, phase_next;
  logic [31:0]      hshift, hshift_next;
  logic [31:0]      cid, cid_next;
  logic [POS_W-1:0] cend, cend_next;
  logic [POS_W-1:0] ips, ips_next;
  logic             err, err_next;

  logic [POS_W-1:0] nxt;
  logic [POS_W-1:0] k;
  logic [31:0]      sh;
  logic [POS_W-1:0] skip_cur;
  logic [POS_W-1:0] new_end;
  logic [POS_W-1:0] skip_new;
  logic             go_bnd;
  logic [POS_W-1:0] bnd_at;
  logic [7:0]       ob;
  stk_ctl_t         ctl;
  stk_stat_t        stat;

  dpirw_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ctl  (ctl),
    .stat (stat)
  );

  assign nxt      = pos + POS_W'(1);
  assign k        = pos - ips;
  assign sh       = {hshift[23:0], byte_in};
  assign skip_cur = cend + POS_W'(cend[0]);
  assign new_end  = nxt + POS_W'(sh);
  assign skip_new = new_end + POS_W'(new_end[0]);

  always_comb begin
    pos_next    = nxt;
    phase_next  = phase;
    hshift_next = hshift;
    cid_next    = cid;
    cend_next   = cend;
    ips_next    = ips;
    err_next    = err;
    go_bnd      = 1'b0;
    bnd_at      = nxt;
    ob          = byte_in;
    ctl         = '0;

    case (phase)
      PH_LEN: begin
        hshift_next = sh;
        if (k >= POS_W'(7)) begin
          cend_next   = new_end;
          ips_next    = nxt;
          hshift_next = '0;
          if (stat.has_top && (new_end > stat.top_end)) begin
            err_next = 1'b1;
          end
          if (cid == ID_FORM) begin
            if (sh < 32'd4) begin
              err_next   = 1'b1;
              phase_next = PH_SKIP;
              go_bnd     = (nxt >= skip_new);
            end else begin
              phase_next = PH_FORMID;
            end
          end else if (cid == ID_INFO) begin
            if (sh < 32'd10) begin
              err_next = 1'b1;
            end
            phase_next = PH_INFO;
            go_bnd     = (nxt >= skip_new);
          end else begin
            phase_next = PH_SKIP;
            go_bnd     = (nxt >= skip_new);
          end
        end
      end
      PH_FORMID: begin
        hshift_next = sh;
        if (k >= POS_W'(3)) begin
          hshift_next = '0;
          if ((sh == ID_DJVU) || (sh == ID_DJVM)) begin
            if (stat.level < LVL_W'(MAX_NESTING)) begin
              ctl.push     = 1'b1;
              ctl.push_end = cend;
              go_bnd       = 1'b1;
            end else begin
              err_next   = 1'b1;
              phase_next = PH_SKIP;
              go_bnd     = (nxt >= skip_cur);
            end
          end else begin
            phase_next = PH_SKIP;
            go_bnd     = (nxt >= skip_cur);
          end
        end
      end
      PH_INFO: begin
        if (pos < cend) begin
          if (k == POS_W'(6)) begin
            ob = target_dpi[7:0];
          end else if (k == POS_W'(7)) begin
            ob = target_dpi[15:8];
          end else if ((k == POS_W'(9)) && (byte_in == 8'd0)) begin
            ob = 8'd1;
          end
        end
        go_bnd = (nxt >= skip_cur);
      end
      PH_SKIP: begin
        go_bnd = (nxt >= skip_cur);
      end
      PH_ID: begin
        hshift_next = sh;
        if (k >= POS_W'(3)) begin
          cid_next    = sh;
          hshift_next = '0;
          if (sh == ID_MAGIC) begin
            go_bnd = 1'b1;
          end else begin
            phase_next = PH_LEN;
          end
        end
      end
      default: begin
        // Unused phase code: restart id parsing at this byte.
        phase_next   = PH_ID;
        ips_next     = pos;
        hshift_next  = {24'd0, byte_in};
        ctl.close    = 1'b1;
        ctl.close_at = pos;
      end
    endcase

    if (go_bnd) begin
      phase_next   = PH_ID;
      hshift_next  = '0;
      ips_next     = bnd_at;
      ctl.close    = 1'b1;
      ctl.close_at = bnd_at;
    end

    // End of file returns the parse state to its reset values; the error flag is kept.
    if (is_last) begin
      pos_next    = '0;
      phase_next  = PH_ID;
      hshift_next = '0;
      cid_next    = '0;
      cend_next   = '0;
      ips_next    = '0;
      ctl.clear   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      phase  <= PH_ID;
      hshift <= '0;
      cid    <= '0;
      cend   <= '0;
      ips    <= '0;
      err    <= 1'b0;
    end else if (step) begin
      pos    <= pos_next;
      phase  <= phase_next;
      hshift <= hshift_next;
      cid    <= cid_next;
      cend   <= cend_next;
      ips    <= ips_next;
      err    <= err_next;
    end
  end

  assign res.byte_val  = ob;
  assign res.patched   = (ob != byte_in);
  assign res.malformed = err_next;

endmodule

FILE: rtl/djvu_info_dpi_rewriter.sv
// ----------------------------------------------------------------------------
// djvu_info_dpi_rewriter
// Streams a DjVu file byte by byte and rewrites the resolution in INFO chunks.
// ----------------------------------------------------------------------------
// An accepted word is loaded into the output register and can be taken in
// the next cycle. Throughput: one word per clock while the output side keeps
// up; the parser state and output register both advance on each accepted
// word, and a new word is taken while the output word is still waiting
// whenever the output side is ready in that cycle.
// Reset: rst is synchronous; it clears the parse state, the core's malformed
// flag and the output valid, and restores target_dpi to 300.
module djvu_info_dpi_rewriter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  byte_out,
  output logic        last_out,
  output logic        patched,
  output logic        malformed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dpirw_pkg::*;

  logic [15:0] target_dpi;
  logic        step;
  logic        reg_sel;
  res_t        res;

  // The output register frees up when its word is taken, so the input side
  // may accept in the same cycle as the output handshake completes.
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  dpirw_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .byte_in    (byte_in),
    .is_last    (is_last),
    .target_dpi (target_dpi),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload registers need no reset.
  always_ff @(posedge clk) begin
    if (step) begin
      byte_out  <= res.byte_val;
      last_out  <= is_last;
      patched   <= res.patched;
      malformed <= res.malformed;
    end
  end

  // Configuration port. The register index is the word address; there is
  // one register, so only word zero is decoded.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_DPI);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_dpi <= DPI_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      target_dpi <= pwdata[15:0];
    end
  end

  assign prdata = reg_sel ? {16'd0, target_dpi} : 32'd0;

endmodule
